// ----- design/rdsd_pkg.sv -----
// Package for the radix digit stream divider.
// Holds the shared constants, the result record and the digit character helpers.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rdsd_pkg;

   // Default width of the divisor and of the running remainder.
   localparam int DIVISOR_BITS_DEFAULT = 31;

   // Fixed field widths of the configuration registers and the result.
   localparam int RADIX_BITS     = 6;
   localparam int DIVISOR_W      = 31;
   localparam int REMAINDER_W    = 31;
   localparam int DIGIT_BITS     = 6;
   localparam int CHAR_BITS      = 8;

   // Quotient digits are below the base, so six restoring steps cover them.
   localparam int QUOT_STEPS     = 6;
   localparam int QUOT_STEP_BITS = 3;

   // Register reset values and the accepted range of the base.
   localparam logic [RADIX_BITS-1:0] RADIX_RESET   = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
   localparam logic [DIVISOR_W-1:0]  DIVISOR_RESET = 31'd1;

   // Register indexes of the configuration port.
   localparam logic CSR_RADIX   = 1'b0;
   localparam logic CSR_DIVISOR = 1'b1;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_A_LOWER = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_Z_LOWER = 8'h7a;
   localparam logic [CHAR_BITS-1:0] CHAR_A_UPPER = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_Z_UPPER = 8'h5a;
   localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 8'h00;

   // Digit value that marks a character that is no digit at all.
   localparam logic [DIGIT_BITS-1:0] DIGIT_INVALID = 6'd36;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN     = 6'd10;

   // One result transaction.
   typedef struct packed {
      logic [CHAR_BITS-1:0]   quot_char;
      logic [REMAINDER_W-1:0] remainder;
      logic                   last;
      logic                   error;
   } result_type;

   // Value of a digit character, either case; DIGIT_INVALID for anything else.
   function automatic logic [DIGIT_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] offset;
      offset = CHAR_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         offset = c - CHAR_ZERO;
      end else if (c >= CHAR_A_LOWER && c <= CHAR_Z_LOWER) begin
         offset = c - CHAR_A_LOWER + {2'b00, DIGIT_TEN};
      end else if (c >= CHAR_A_UPPER && c <= CHAR_Z_UPPER) begin
         offset = c - CHAR_A_UPPER + {2'b00, DIGIT_TEN};
      end else begin
         offset = {2'b00, DIGIT_INVALID};
      end
      return offset[DIGIT_BITS-1:0];
   endfunction

   // Lower case character of a digit value below 36.
   function automatic logic [CHAR_BITS-1:0] value_char(input logic [DIGIT_BITS-1:0] v);
      logic [CHAR_BITS-1:0] wide;
      wide = {2'b00, v};
      if (v < DIGIT_TEN) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A_LOWER + wide - {2'b00, DIGIT_TEN};
   endfunction

endpackage

`default_nettype wire

// ----- design/rdsd_cmpsub.sv -----
// Shared compare-subtract unit of the divider.
// One wide subtraction whose borrow gives the compare; uses rdsd_pkg only for its default width.
`default_nettype none

module rdsd_cmpsub #(
   parameter int WIDTH = rdsd_pkg::DIVISOR_BITS_DEFAULT + rdsd_pkg::DIGIT_BITS
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   output logic                  ge,
   output logic [WIDTH-1:0]      diff
);

   logic [WIDTH:0] wide_diff;

   // The borrow out of a - b is clear exactly when a is at least b.
   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign ge        = ~wide_diff[WIDTH];
   assign diff      = wide_diff[WIDTH-1:0];

endmodule

`default_nettype wire

// ----- design/rdsd_engine.sv -----
// Sequencer and datapath of the digit divider.
// Drives the shared rdsd_cmpsub unit and keeps the running remainder state.
// Uses rdsd_pkg for the result record and the character helpers.
`default_nettype none

module rdsd_engine #(
   parameter int DIVISOR_BITS = rdsd_pkg::DIVISOR_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [rdsd_pkg::CHAR_BITS-1:0]    in_char,
   input  wire logic                              in_last,
   input  wire logic [rdsd_pkg::RADIX_BITS-1:0]   base,
   input  wire logic [DIVISOR_BITS-1:0]           divisor,
   output logic                                   res_valid,
   input  wire logic                              res_ready,
   output rdsd_pkg::result_type                   res
);

   localparam int W  = DIVISOR_BITS + rdsd_pkg::DIGIT_BITS;
   localparam int CW = $clog2(DIVISOR_BITS);
   localparam int SW = (CW > rdsd_pkg::QUOT_STEP_BITS) ? CW : rdsd_pkg::QUOT_STEP_BITS;
   localparam int PW = W + rdsd_pkg::REMAINDER_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_MUL,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic                               skipping_ff;
   logic                               started_ff;
   logic [DIVISOR_BITS-1:0]            run_rem_ff;
   logic [DIVISOR_BITS-1:0]            src_ff;
   logic [W-1:0]                       num_ff;
   logic [rdsd_pkg::DIGIT_BITS-1:0]    q_ff;
   logic [SW-1:0]                      step_ff;
   logic [rdsd_pkg::DIGIT_BITS-1:0]    digit_ff;
   logic                               last_ff;
   rdsd_pkg::result_type               res_ff;

   logic [W-1:0]                       unit_a;
   logic [W-1:0]                       unit_b;
   logic                               unit_ge;
   logic [W-1:0]                       unit_diff;
   logic [W-1:0]                       d_wide;
   logic [rdsd_pkg::DIGIT_BITS-1:0]    char_val;
   logic [DIVISOR_BITS-1:0]            rem_in;
   logic [W-1:0]                       product;
   logic [W-1:0]                       num_in;
   logic [W-1:0]                       num_after;
   logic [rdsd_pkg::DIGIT_BITS-1:0]    q_bit;
   logic [rdsd_pkg::DIGIT_BITS-1:0]    q_next;
   logic [PW-1:0]                      num_pad;
   logic [rdsd_pkg::REMAINDER_W-1:0]   rem_out;

   assign d_wide   = W'(divisor);
   assign char_val = rdsd_pkg::char_value(in_char);

   // Operand selection for the shared unit: remainder check, reduction step
   // or one quotient bit against the shifted divisor.
   always_comb begin
      case (state_ff)
         ST_CHECK: begin
            unit_a = W'(run_rem_ff);
            unit_b = d_wide;
         end
         ST_REDUCE: begin
            unit_a = W'({run_rem_ff, src_ff[DIVISOR_BITS-1]});
            unit_b = d_wide;
         end
         ST_DIVIDE: begin
            unit_a = num_ff;
            unit_b = d_wide << step_ff[rdsd_pkg::QUOT_STEP_BITS-1:0];
         end
         default: begin
            unit_a = num_ff;
            unit_b = d_wide;
         end
      endcase
   end

   rdsd_cmpsub #(
      .WIDTH (W)
   ) u_cmpsub (
      .a    (unit_a),
      .b    (unit_b),
      .ge   (unit_ge),
      .diff (unit_diff)
   );

   // Results of one unit step as seen by each state.
   always_comb begin
      rem_in    = unit_ge ? unit_diff[DIVISOR_BITS-1:0] : unit_a[DIVISOR_BITS-1:0];
      product   = W'(base) * W'(run_rem_ff);
      num_in    = product + W'(digit_ff);
      num_after = unit_ge ? unit_diff : num_ff;
      q_bit     = rdsd_pkg::DIGIT_BITS'(unit_ge) << step_ff[rdsd_pkg::QUOT_STEP_BITS-1:0];
      q_next    = q_ff | q_bit;
      num_pad   = PW'(num_after);
      rem_out   = num_pad[rdsd_pkg::REMAINDER_W-1:0];
   end

   // Sequencer: accept, optional reduction of a stale remainder, multiply,
   // six quotient steps, then hand the result over.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         skipping_ff <= 1'b0;
         started_ff  <= 1'b0;
         run_rem_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  if (skipping_ff) begin
                     // Discard characters until the end of the number.
                     if (in_last) begin
                        skipping_ff <= 1'b0;
                     end
                  end else if (char_val >= base) begin
                     // Bad digit: one error transaction, then skip the rest.
                     run_rem_ff       <= '0;
                     started_ff       <= 1'b0;
                     skipping_ff      <= ~in_last;
                     res_ff.quot_char <= rdsd_pkg::CHAR_NONE;
                     res_ff.remainder <= '0;
                     res_ff.last      <= in_last;
                     res_ff.error     <= 1'b1;
                     state_ff         <= ST_DONE;
                  end else begin
                     digit_ff <= char_val;
                     last_ff  <= in_last;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               // A divisor lowered since the last digit needs a reduction first.
               if (unit_ge) begin
                  src_ff     <= run_rem_ff;
                  run_rem_ff <= '0;
                  step_ff    <= SW'(DIVISOR_BITS - 1);
                  state_ff   <= ST_REDUCE;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_REDUCE: begin
               run_rem_ff <= rem_in;
               src_ff     <= src_ff << 1;
               if (step_ff == '0) begin
                  state_ff <= ST_MUL;
               end else begin
                  step_ff <= step_ff - SW'(1);
               end
            end
            ST_MUL: begin
               num_ff   <= num_in;
               q_ff     <= '0;
               step_ff  <= SW'(rdsd_pkg::QUOT_STEPS - 1);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               num_ff <= num_after;
               q_ff   <= q_next;
               if (step_ff != '0) begin
                  step_ff <= step_ff - SW'(1);
               end else if (last_ff) begin
                  // Last digit always reports, with the final remainder.
                  res_ff.quot_char <= rdsd_pkg::value_char(q_next);
                  res_ff.remainder <= rem_out;
                  res_ff.last      <= 1'b1;
                  res_ff.error     <= 1'b0;
                  run_rem_ff       <= '0;
                  started_ff       <= 1'b0;
                  state_ff         <= ST_DONE;
               end else begin
                  run_rem_ff <= num_after[DIVISOR_BITS-1:0];
                  if (q_next != '0 || started_ff) begin
                     started_ff       <= 1'b1;
                     res_ff.quot_char <= rdsd_pkg::value_char(q_next);
                     res_ff.remainder <= '0;
                     res_ff.last      <= 1'b0;
                     res_ff.error     <= 1'b0;
                     state_ff         <= ST_DONE;
                  end else begin
                     // Leading zero digits are suppressed.
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_DONE: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire

// ----- design/radix_digit_stream_divider.sv -----
// Top level of the radix digit stream divider.
// Holds the configuration registers and the result register around rdsd_engine.
// Depends on rdsd_pkg, rdsd_cmpsub and rdsd_engine.
`default_nettype none

// Long-divides a number, streamed as digit characters most significant first,
// by the divisor register in the base given by the radix register. A digit
// that yields a result is accepted, the stored remainder is checked, the
// multiply is done, six compare-subtract steps of the shared unit form the
// quotient digit and the result is passed on (held while the result register
// is stalled); only then is the next character accepted. A suppressed leading
// zero passes nothing on. When the divisor was lowered between two digits of
// a number, the stored remainder is first reduced bit by bit before the
// multiply. A digit that gives an error passes its error result on straight
// after it is accepted; a discarded character is only accepted. Quotient
// digits come out in lower case with leading zeros suppressed; the last digit
// always yields a result that carries the final remainder. A bad character
// yields one error result and the rest of the number is dropped. Out-of-range
// bases are clamped to 2..36 and a zero divisor acts as 1. Registers may be
// written only while no digit is in work.
module radix_digit_stream_divider #(
   parameter int DIVISOR_BITS = rdsd_pkg::DIVISOR_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input: tdata = digit_char[7:0]; tlast = is_last.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tlast,
   // Output: tdata = quotient_char[7:0], remainder_out[38:8], zero fill[39].
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [39:0]                            rsp_tdata,
   output logic                                   rsp_tlast,
   // Output: tuser = error.
   output logic                                   rsp_tuser,
   // Configuration write port.
   input  wire logic                              csr_wen,
   input  wire logic                              csr_index,
   input  wire logic [rdsd_pkg::DIVISOR_W-1:0]    csr_wdata
);

   localparam int PW = DIVISOR_BITS + rdsd_pkg::DIVISOR_W;

   logic [rdsd_pkg::RADIX_BITS-1:0]   radix_ff;
   logic [rdsd_pkg::DIVISOR_W-1:0]    divisor_ff;
   logic                              rsp_valid_ff;
   rdsd_pkg::result_type              rsp_data_ff;

   logic [rdsd_pkg::RADIX_BITS-1:0]   base;
   logic [PW-1:0]                     divisor_pad;
   logic [DIVISOR_BITS-1:0]           divisor_raw;
   logic [DIVISOR_BITS-1:0]           divisor_eff;
   logic                              eng_valid;
   logic                              eng_ready;
   rdsd_pkg::result_type              eng_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff   <= rdsd_pkg::RADIX_RESET;
         divisor_ff <= rdsd_pkg::DIVISOR_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            rdsd_pkg::CSR_RADIX: begin
               radix_ff <= csr_wdata[rdsd_pkg::RADIX_BITS-1:0];
            end
            rdsd_pkg::CSR_DIVISOR: begin
               divisor_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the base and fit the divisor to the datapath width.
   always_comb begin
      if (radix_ff < rdsd_pkg::RADIX_MIN) begin
         base = rdsd_pkg::RADIX_MIN;
      end else if (radix_ff > rdsd_pkg::RADIX_MAX) begin
         base = rdsd_pkg::RADIX_MAX;
      end else begin
         base = radix_ff;
      end
      divisor_pad = PW'(divisor_ff);
      divisor_raw = divisor_pad[DIVISOR_BITS-1:0];
      divisor_eff = (divisor_raw == '0) ? DIVISOR_BITS'(1) : divisor_raw;
   end

   rdsd_engine #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_char   (req_tdata),
      .in_last   (req_tlast),
      .base      (base),
      .divisor   (divisor_eff),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   // Result register; the engine hands a result over only while it is empty or being read.
   assign eng_ready = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_ready) begin
         rsp_valid_ff <= eng_valid;
         if (eng_valid) begin
            rsp_data_ff <= eng_res;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.remainder, rsp_data_ff.quot_char};
   assign rsp_tlast  = rsp_data_ff.last;
   assign rsp_tuser  = rsp_data_ff.error;

   // An error transaction carries no quotient character and no remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error result with nonzero payload");

   // Only the final transaction of a number carries a remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[39:8] == '0)
      else $error("remainder on a result that is not last");

   // A good transaction always holds a lower case digit character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[7:0] >= rdsd_pkg::CHAR_ZERO && rsp_tdata[7:0] <= rdsd_pkg::CHAR_NINE) ||
         (rsp_tdata[7:0] >= rdsd_pkg::CHAR_A_LOWER &&
          rsp_tdata[7:0] <= rdsd_pkg::CHAR_Z_LOWER))
      else $error("quotient character out of range");

endmodule

`default_nettype wire

// ----- tb/tb_radix_digit_stream_divider.sv -----
// Self-checking testbench for radix_digit_stream_divider.
// Streams digit characters under many base and divisor settings and checks each result.
// Depends on rdsd_pkg and the radix_digit_stream_divider RTL.
`timescale 1ns / 100ps

module tb_radix_digit_stream_divider;

   // Cycles to let the block finish a digit that gives no result, including
   // the remainder reduction after a lowered divisor.
   localparam int SETTLE_CYCLES = 64;
   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT   = 5000;
   // Target number of input transactions for the whole run.
   localparam int DIGIT_TARGET  = 1400;
   localparam int HOLD_CYCLES   = 400;

   // Field widths used in size casts.
   localparam int RADIX_W = rdsd_pkg::RADIX_BITS;
   localparam int DIV_W   = rdsd_pkg::DIVISOR_W;
   localparam int JUNK_W  = DIV_W - RADIX_W;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [7:0]         req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [39:0]        rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_wen;
   logic               csr_index;
   logic [DIV_W-1:0]   csr_wdata;

   // Shadow registers and division state of the predictor.
   logic [RADIX_W-1:0]   radix_reg    = rdsd_pkg::RADIX_RESET;
   logic [DIV_W-1:0]     divisor_reg  = rdsd_pkg::DIVISOR_RESET;
   longint unsigned      partial_rem  = 0;
   bit                   quot_started = 1'b0;
   bit                   dropping     = 1'b0;
   rdsd_pkg::result_type quotients_due[$];

   int mismatches      = 0;
   int digits_used     = 0;
   int results_checked = 0;
   int errors_checked  = 0;
   int configs_used    = 0;
   int idle_cycles     = 0;
   int rsp_hold        = 0;
   bit quiet           = 1'b0;
   bit offering        = 1'b0;

   radix_digit_stream_divider i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Digit value of a character, DIGIT_INVALID when it is no digit.
   function automatic int digit_of(input logic [7:0] c);
      if (c >= rdsd_pkg::CHAR_ZERO && c <= rdsd_pkg::CHAR_NINE)
         return int'(c - rdsd_pkg::CHAR_ZERO);
      if (c >= rdsd_pkg::CHAR_A_LOWER && c <= rdsd_pkg::CHAR_Z_LOWER)
         return int'(c - rdsd_pkg::CHAR_A_LOWER) + 10;
      if (c >= rdsd_pkg::CHAR_A_UPPER && c <= rdsd_pkg::CHAR_Z_UPPER)
         return int'(c - rdsd_pkg::CHAR_A_UPPER) + 10;
      return int'(rdsd_pkg::DIGIT_INVALID);
   endfunction

   function automatic logic [7:0] char_of(input int v, input bit upper);
      if (v < 10) return rdsd_pkg::CHAR_ZERO + 8'(v);
      return (upper ? rdsd_pkg::CHAR_A_UPPER : rdsd_pkg::CHAR_A_LOWER) + 8'(v - 10);
   endfunction

   // Base actually used: the register clamped to 2..36.
   function automatic int eff_radix();
      int b;
      b = int'(radix_reg);
      if (b < 2) b = 2;
      if (b > 36) b = 36;
      return b;
   endfunction

   // One long-division step; returns 1 when the digit produces a result.
   function automatic bit divide_digit(input logic [7:0] c, input logic last,
                                       output rdsd_pkg::result_type res);
      longint unsigned base;
      longint unsigned d;
      longint unsigned acc;
      longint unsigned q;
      int v;
      res = '0;
      base = longint'(eff_radix());
      d = (divisor_reg == '0) ? 1 : longint'(divisor_reg);
      if (dropping) begin
         if (last) dropping = 1'b0;
         return 1'b0;
      end
      v = digit_of(c);
      if (v >= eff_radix()) begin
         partial_rem = 0;
         quot_started = 1'b0;
         dropping = !last;
         res.last = last;
         res.error = 1'b1;
         return 1'b1;
      end
      // A divisor lowered mid-number leaves a stored remainder above it.
      acc = base * (partial_rem % d) + longint'(v);
      q = acc / d;
      acc = acc % d;
      if (last) begin
         res.quot_char = char_of(int'(q), 1'b0);
         res.remainder = acc[rdsd_pkg::REMAINDER_W-1:0];
         res.last = 1'b1;
         partial_rem = 0;
         quot_started = 1'b0;
         return 1'b1;
      end
      partial_rem = acc;
      if (q > 0 || quot_started) begin
         quot_started = 1'b1;
         res.quot_char = char_of(int'(q), 1'b0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Receiver: random stalls, a counted hold-off on request, none while quiet.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (!quiet && $urandom_range(0, 99) < 9) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      rdsd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quotients_due.size() == 0) begin
            $error("result with nothing expected: tdata %h tlast %b tuser %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            want = quotients_due.pop_front();
            results_checked++;
            if (want.error) errors_checked++;
            if (rsp_tdata[7:0] !== want.quot_char) begin
               $error("quotient_char: expected %h, got %h", want.quot_char, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[38:8] !== want.remainder) begin
               $error("remainder_out: expected %0d, got %0d", want.remainder, rsp_tdata[38:8]);
               mismatches++;
            end
            if (rsp_tdata[39] !== 1'b0) begin
               $error("tdata fill: expected 0, got %b", rsp_tdata[39]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out: expected %b, got %b", want.last, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.error) begin
               $error("error: expected %b, got %b", want.error, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction of any kind happens.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one digit, with random gaps before it, and predict it on acceptance.
   // Called and returning at a falling edge; tvalid stays high for the next call.
   task automatic send_digit(input logic [7:0] c, input logic last);
      rdsd_pkg::result_type res;
      while (!quiet && $urandom_range(0, 99) < 9) begin
         if (offering) req_tvalid <= 1'b0;
         offering = 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      digits_used++;
      if (divide_digit(c, last, res)) quotients_due.push_back(res);
      @(negedge clock);
   endtask

   // Stop offering, drain every expected result, then let the engine go idle.
   task automatic settle();
      if (offering) req_tvalid <= 1'b0;
      offering = 1'b0;
      while (quotients_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write both registers while idle; the radix write carries junk upper bits.
   task automatic set_config(input logic [RADIX_W-1:0] r, input logic [DIV_W-1:0] d);
      logic [JUNK_W-1:0] junk;
      junk = JUNK_W'($urandom());
      settle();
      csr_wen   <= 1'b1;
      csr_index <= rdsd_pkg::CSR_RADIX;
      csr_wdata <= {junk, r};
      radix_reg = r;
      @(negedge clock);
      csr_index <= rdsd_pkg::CSR_DIVISOR;
      csr_wdata <= d;
      divisor_reg = d;
      @(negedge clock);
      csr_wen <= 1'b0;
      configs_used++;
   endtask

   // A character the current base rejects: no digit at all, or one too large.
   function automatic logic [7:0] bad_char(input int base);
      logic [7:0] c;
      if (base < 36 && $urandom_range(0, 1) == 1)
         return char_of(int'($urandom_range(base, 35)), 1'($urandom_range(0, 1)));
      do c = 8'($urandom_range(0, 255)); while (digit_of(c) != int'(rdsd_pkg::DIGIT_INVALID));
      return c;
   endfunction

   // A number of random digits in either case, sometimes corrupted or noisy.
   task automatic send_random_number();
      int len;
      int bad_at;
      int base;
      int i;
      logic [7:0] c;
      base = eff_radix();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      bad_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, len - 1) : -1;
      for (i = 0; i < len; i++) begin
         if (i == bad_at) c = bad_char(base);
         else if ($urandom_range(0, 99) < 4) c = 8'($urandom_range(0, 255));
         else c = char_of(int'($urandom_range(0, base - 1)), 1'($urandom_range(0, 1)));
         send_digit(c, i == len - 1);
      end
   endtask

   // Reset values: base 10, divisor 1, so quotient digits echo the input.
   task automatic test_default_config();
      send_digit("0", 1'b1);
      send_digit("9", 1'b0);
      send_digit("0", 1'b1);
   endtask

   // Bad characters give one error result, and the rest of the number is dropped.
   task automatic test_invalid_chars();
      send_digit("a", 1'b0);
      send_digit(8'hff, 1'b0);
      send_digit("5", 1'b1);
      send_digit(":", 1'b1);
      send_digit(8'h00, 1'b1);
      send_digit("/", 1'b0);
      send_digit("{", 1'b1);
   endtask

   // Out-of-range base and zero divisor are clamped.
   task automatic test_clamped_config();
      set_config(6'd63, '0);
      send_digit("Z", 1'b0);
      send_digit("z", 1'b1);
      set_config(6'd0, '0);
      send_digit("2", 1'b1);
      send_digit("1", 1'b1);
   endtask

   // Largest divisor: leading zeros suppressed until the last digit.
   task automatic test_wide_divisor();
      int i;
      set_config(rdsd_pkg::RADIX_MAX, {DIV_W{1'b1}});
      for (i = 0; i < 6; i++) send_digit("z", i == 5);
   endtask

   // Divisor lowered between two digits of one number.
   task automatic test_register_change();
      set_config(6'd10, 31'd1000);
      send_digit("9", 1'b0);
      send_digit("9", 1'b0);
      set_config(6'd10, 31'd7);
      send_digit("9", 1'b1);
   endtask

   // Receiver holds off for a long stretch while digits keep coming.
   task automatic test_stalled_receiver();
      int i;
      set_config(6'd16, 31'd3);
      quiet = 1'b1;
      rsp_hold = HOLD_CYCLES;
      for (i = 0; i < 48; i++)
         send_digit(char_of(int'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), i % 8 == 7);
      quiet = 1'b0;
   endtask

   // Random settings, extremes among them, each with a run of random numbers,
   // until the run as a whole has sent about DIGIT_TARGET input transactions.
   task automatic test_random_numbers();
      logic [RADIX_W-1:0] r;
      logic [DIV_W-1:0]   d;
      int target;
      int phase_end;
      int phase;
      target = DIGIT_TARGET;
      phase = 0;
      while (digits_used < target) begin
         case ($urandom_range(0, 11))
            0:       r = 6'd0;
            1:       r = 6'd1;
            2:       r = rdsd_pkg::RADIX_MIN;
            3:       r = rdsd_pkg::RADIX_MAX;
            4:       r = 6'd37;
            5:       r = 6'd63;
            default: r = RADIX_W'($urandom_range(0, 63));
         endcase
         case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = 31'd1;
            2, 3:    d = DIV_W'($urandom_range(2, 50));
            4:       d = {DIV_W{1'b1}};
            5:       d = 31'd1 << $urandom_range(1, 30);
            6:       d = DIV_W'($urandom());
            default: d = DIV_W'($urandom_range(51, 5000));
         endcase
         set_config(r, d);
         // One setting runs with neither side idling.
         quiet = (phase == 2);
         phase_end = digits_used + int'($urandom_range(60, 140));
         if (phase_end > target) phase_end = target;
         while (digits_used < phase_end) send_random_number();
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = rdsd_pkg::CSR_RADIX;
      csr_wdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_invalid_chars();
      test_clamped_config();
      test_wide_divisor();
      test_register_change();
      test_stalled_receiver();
      test_random_numbers();
      settle();

      $display("Checked %0d results (%0d error results) from %0d digit characters over %0d settings,",
               results_checked, errors_checked, digits_used, configs_used);
      $display("including a %0d-cycle receiver hold-off with the input stalled.", HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
